// ===== sv/record_ring_log_buffer_macros.svh =====
// Assertion macros shared by the record ring log buffer modules.
// Each macro expects clk_i and rst_ni in scope.
`ifndef RECORD_RING_LOG_BUFFER_MACROS_SVH
`define RECORD_RING_LOG_BUFFER_MACROS_SVH

// Same-cycle implication.
`define RRLB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrlb assertion failed");

// Next-cycle implication.
`define RRLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrlb assertion failed");

`endif

// ===== sv/rrlb_pkg.sv =====
// Shared types and codes for the record ring log buffer.
// No dependencies.
package rrlb_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_RDHDR  = 2'd2;
  localparam logic [1:0] OP_RDBYTE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_TOOLARGE = 3'd2;
  localparam logic [2:0] ST_TOOSMALL = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_WRITING = 2'd1;
  localparam logic [1:0] MODE_READING = 2'd2;

  localparam int HDR_BYTES = 24;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  record_length;
    logic [15:0] process_id;
    logic [15:0] task_id;
    logic [31:0] seconds;
    logic [31:0] nanoseconds;
    logic [7:0]  data_byte;
    logic [15:0] reader_capacity;
  } item_t;

endpackage

// ===== sv/record_ring_log_buffer.sv =====
// Record ring log buffer top level. Append, busy and error beats answer
// from idle; read byte runs the byte-read state, start_record eviction
// and header write, read_header header read and decode. The engine takes
// one beat at a time; a two-entry queue accepts beats while a result waits.
// Reset is asynchronous, active low, and empties the ring at once.
module record_ring_log_buffer #(
  parameter int BUF_BYTES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            operation_i,
  input  logic [9:0]                            record_length_i,
  input  logic [15:0]                           process_id_i,
  input  logic [15:0]                           task_id_i,
  input  logic [31:0]                           seconds_i,
  input  logic [31:0]                           nanoseconds_i,
  input  logic [7:0]                            data_byte_i,
  input  logic [15:0]                           reader_capacity_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [2:0]                            status_o,
  output logic [9:0]                            out_length_o,
  output logic [15:0]                           out_process_o,
  output logic [15:0]                           out_task_o,
  output logic [31:0]                           out_seconds_o,
  output logic [31:0]                           out_nanoseconds_o,
  output logic [7:0]                            out_byte_o,
  output logic                                  last_byte_o,
  output logic [$clog2(BUF_BYTES / 24 + 1)-1:0] records_held_o,
  output logic [$clog2(BUF_BYTES):0]            bytes_held_o
);
  import rrlb_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_pop;

  always_comb begin
    in_item.operation       = operation_i;
    in_item.record_length   = record_length_i;
    in_item.process_id      = process_id_i;
    in_item.task_id         = task_id_i;
    in_item.seconds         = seconds_i;
    in_item.nanoseconds     = nanoseconds_i;
    in_item.data_byte       = data_byte_i;
    in_item.reader_capacity = reader_capacity_i;
  end

  rrlb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  rrlb_engine #(
    .BUF_BYTES (BUF_BYTES)
  ) u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .out_length_o      (out_length_o),
    .out_process_o     (out_process_o),
    .out_task_o        (out_task_o),
    .out_seconds_o     (out_seconds_o),
    .out_nanoseconds_o (out_nanoseconds_o),
    .out_byte_o        (out_byte_o),
    .last_byte_o       (last_byte_o),
    .records_held_o    (records_held_o),
    .bytes_held_o      (bytes_held_o)
  );

endmodule

// ===== sv/rrlb_front.sv =====
// Front queue of the record ring log buffer: accepts input beats into a
// two-entry queue. Depends on rrlb_pkg.
module rrlb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rrlb_pkg::item_t in_item_i,
  output logic            q_valid_o,
  output rrlb_pkg::item_t q_item_o,
  input  logic            q_pop_i
);
  import rrlb_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ===== sv/rrlb_engine.sv =====
// Back engine of the record ring log buffer: byte ring memory, eviction,
// header write and read sequencing, result register. Depends on rrlb_pkg.
`include "record_ring_log_buffer_macros.svh"
module rrlb_engine #(
  parameter int BUF_BYTES = 1024,
  parameter int AW = $clog2(BUF_BYTES),
  parameter int RW = $clog2(BUF_BYTES / 24 + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  rrlb_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      status_o,
  output logic [9:0]      out_length_o,
  output logic [15:0]     out_process_o,
  output logic [15:0]     out_task_o,
  output logic [31:0]     out_seconds_o,
  output logic [31:0]     out_nanoseconds_o,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o,
  output logic [RW-1:0]   records_held_o,
  output logic [AW:0]     bytes_held_o
);
  import rrlb_pkg::*;

  localparam int SW = (AW + 2 > 12) ? AW + 2 : 12;
  localparam logic [SW-1:0] BUF_S = SW'(BUF_BYTES);
  localparam logic [SW-1:0] HDR_S = SW'(HDR_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVCHK = 3'd1;
  localparam logic [2:0] S_EVL0  = 3'd2;
  localparam logic [2:0] S_EVL1  = 3'd3;
  localparam logic [2:0] S_HWR   = 3'd4;
  localparam logic [2:0] S_HRD   = 3'd5;
  localparam logic [2:0] S_HDEC  = 3'd6;
  localparam logic [2:0] S_BRD   = 3'd7;

  logic [7:0]    mem [BUF_BYTES];
  logic [7:0]    rd_q;
  logic [AW-1:0] raddr, waddr;
  logic [7:0]    wdata;
  logic          we;

  logic [2:0]    state_q, state_d;
  logic [4:0]    cnt_q, cnt_d;
  item_t         item_q, item_d;
  logic [7:0]    lo_q, lo_d;
  logic [159:0]  hbuf_q, hbuf_d;
  logic [AW-1:0] wp_q, wp_d, head_q, head_d;
  logic [AW:0]   occ_q, occ_d;
  logic [RW-1:0] total_q, total_d;
  logic [1:0]    mode_q, mode_d;
  logic [9:0]    rem_q, rem_d;

  logic          ov_q, ov_d;
  logic [2:0]    st_q, st_d;
  logic [9:0]    len_q, len_d;
  logic [15:0]   pr_q, pr_d, tk_q, tk_d;
  logic [31:0]   sec_q, sec_d, ns_q, ns_d;
  logic [7:0]    ob_q, ob_d;
  logic          lb_q, lb_d;

  logic [191:0]  hdr_vec;
  logic [SW-1:0] need, drop, rlen_s;
  logic [9:0]    rlen;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW:0] k);
    logic [AW+1:0] s;
    s = {2'b00, a} + {1'b0, k};
    if (s >= (AW+2)'(BUF_BYTES)) begin
      s = s - (AW+2)'(BUF_BYTES);
    end
    return s[AW-1:0];
  endfunction

  assign hdr_vec = {32'd0, item_q.nanoseconds, item_q.seconds,
                    item_q.task_id, item_q.process_id,
                    32'd24, 22'd0, item_q.record_length};
  assign need    = SW'(item_q.record_length) + HDR_S;
  assign drop    = HDR_S + SW'({rd_q[1:0], lo_q});
  assign rlen    = {hbuf_q[9:8], hbuf_q[7:0]};
  assign rlen_s  = SW'(rlen) + HDR_S;

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  item_d = item_q;  lo_d = lo_q;
    hbuf_d = hbuf_q;    wp_d = wp_q;    head_d = head_q;  occ_d = occ_q;
    total_d = total_q;  mode_d = mode_q; rem_d = rem_q;
    ov_d = ov_q;  st_d = st_q;  len_d = len_q;  pr_d = pr_q;  tk_d = tk_q;
    sec_d = sec_q;  ns_d = ns_q;  ob_d = ob_q;  lb_d = lb_q;
    q_pop_o = 1'b0;
    we = 1'b0;  waddr = wp_q;  wdata = 8'd0;  raddr = head_q;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !ov_q) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          st_d = ST_OK;  len_d = 10'd0;  pr_d = 16'd0;  tk_d = 16'd0;
          sec_d = 32'd0; ns_d = 32'd0;   ob_d = 8'd0;   lb_d = 1'b0;
          ov_d = 1'b1;
          case (q_item_i.operation)
            OP_START: begin
              if (mode_q != MODE_IDLE) begin
                st_d = ST_BUSY;
              end else if (SW'(q_item_i.record_length) + HDR_S > BUF_S) begin
                st_d = ST_TOOLARGE;
              end else begin
                ov_d    = 1'b0;
                state_d = S_EVCHK;
              end
            end
            OP_APPEND: begin
              if (mode_q != MODE_WRITING) begin
                st_d = ST_BUSY;
              end else begin
                we    = 1'b1;
                wdata = q_item_i.data_byte;
                wp_d  = ring_add(wp_q, (AW+1)'(1));
                occ_d = occ_q + 1'b1;
                rem_d = rem_q - 10'd1;
                if (rem_q == 10'd1) begin
                  total_d = total_q + 1'b1;
                  mode_d  = MODE_IDLE;
                end
              end
            end
            OP_RDHDR: begin
              if (mode_q != MODE_IDLE) begin
                st_d = ST_BUSY;
              end else if (total_q == '0 || SW'(occ_q) < HDR_S) begin
                st_d = ST_EMPTY;
              end else begin
                ov_d    = 1'b0;
                cnt_d   = 5'd0;
                state_d = S_HRD;
              end
            end
            default: begin
              if (mode_q != MODE_READING || occ_q == '0) begin
                st_d = ST_BUSY;
              end else begin
                ov_d    = 1'b0;
                raddr   = head_q;
                state_d = S_BRD;
              end
            end
          endcase
        end
      end
      S_EVCHK: begin
        raddr = head_q;
        if (need + SW'(occ_q) >= BUF_S && occ_q != '0) begin
          state_d = S_EVL0;
        end else begin
          cnt_d   = 5'd0;
          state_d = S_HWR;
        end
      end
      S_EVL0: begin
        raddr   = ring_add(head_q, (AW+1)'(1));
        lo_d    = rd_q;
        state_d = S_EVL1;
      end
      S_EVL1: begin
        if (drop > SW'(occ_q)) begin
          head_d  = wp_q;
          occ_d   = '0;
          total_d = '0;
        end else begin
          head_d = ring_add(head_q, drop[AW:0]);
          occ_d  = occ_q - drop[AW:0];
          if (total_q != '0) begin
            total_d = total_q - 1'b1;
          end
        end
        state_d = S_EVCHK;
      end
      S_HWR: begin
        we    = 1'b1;
        wdata = hdr_vec[8*cnt_q +: 8];
        wp_d  = ring_add(wp_q, (AW+1)'(1));
        occ_d = occ_q + 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd23) begin
          if (item_q.record_length == 10'd0) begin
            total_d = total_q + 1'b1;
          end else begin
            mode_d = MODE_WRITING;
            rem_d  = item_q.record_length;
          end
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_HRD: begin
        raddr = ring_add(head_q, (AW+1)'(cnt_q));
        if (cnt_q != 5'd0) begin
          hbuf_d[8*(cnt_q - 5'd1) +: 8] = rd_q;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd20) begin
          state_d = S_HDEC;
        end
      end
      S_HDEC: begin
        len_d = rlen;
        ov_d  = 1'b1;
        if (SW'(item_q.reader_capacity) < rlen_s || rlen_s > SW'(occ_q)) begin
          st_d = ST_TOOSMALL;
        end else begin
          pr_d    = hbuf_q[79:64];
          tk_d    = hbuf_q[95:80];
          sec_d   = hbuf_q[127:96];
          ns_d    = hbuf_q[159:128];
          head_d  = ring_add(head_q, (AW+1)'(HDR_BYTES));
          occ_d   = occ_q - (AW+1)'(HDR_BYTES);
          total_d = total_q - 1'b1;
          if (rlen != 10'd0) begin
            mode_d = MODE_READING;
            rem_d  = rlen;
          end
        end
        state_d = S_IDLE;
      end
      S_BRD: begin
        ob_d   = rd_q;
        head_d = ring_add(head_q, (AW+1)'(1));
        occ_d  = occ_q - 1'b1;
        rem_d  = rem_q - 10'd1;
        if (rem_q == 10'd1) begin
          lb_d   = 1'b1;
          mode_d = MODE_IDLE;
        end
        ov_d    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;  lo_q <= lo_d;  hbuf_q <= hbuf_d;
    st_q <= st_d;  len_q <= len_d;  pr_q <= pr_d;  tk_q <= tk_d;
    sec_q <= sec_d;  ns_q <= ns_d;  ob_q <= ob_d;  lb_q <= lb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 5'd0;
      wp_q    <= '0;
      head_q  <= '0;
      occ_q   <= '0;
      total_q <= '0;
      mode_q  <= MODE_IDLE;
      rem_q   <= 10'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wp_q    <= wp_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
      total_q <= total_d;
      mode_q  <= mode_d;
      rem_q   <= rem_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o       = ov_q;
  assign status_o          = st_q;
  assign out_length_o      = len_q;
  assign out_process_o     = pr_q;
  assign out_task_o        = tk_q;
  assign out_seconds_o     = sec_q;
  assign out_nanoseconds_o = ns_q;
  assign out_byte_o        = ob_q;
  assign last_byte_o       = lb_q;
  assign records_held_o    = total_q;
  assign bytes_held_o      = occ_q;

  `RRLB_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= (AW+1)'(BUF_BYTES))
  `RRLB_ASSERT_NOW(a_mode_rem, mode_q != MODE_IDLE, rem_q != 10'd0)
  `RRLB_ASSERT_NEXT(a_hold_state, ov_q && out_stall_i, $stable(occ_q) && $stable(mode_q))

endmodule
